@@ sv/murmurhash2_stream_defines.svh @@
// assertion macros for the murmurhash2 stream block
// used by murmurhash2_stream.sv, expects clk and rst_n in scope
`ifndef MURMURHASH2_STREAM_DEFINES_SVH
`define MURMURHASH2_STREAM_DEFINES_SVH

`ifndef SYNTHESIS
`define MH2S_ASSERT_NOW(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("mh2s assertion failed");
`define MH2S_ASSERT_NEXT(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("mh2s assertion failed");
`else
`define MH2S_ASSERT_NOW(lbl, cond, expr)
`define MH2S_ASSERT_NEXT(lbl, cond, expr)
`endif

`endif

@@ sv/mh2s_pkg.sv @@
// shared constants and types for the murmurhash2 stream block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mh2s_pkg;

  localparam logic [31:0] MIX_MUL     = 32'h5bd1_e995;
  localparam int          MIX_SHIFT   = 24;
  localparam int          FIN_SHIFT_A = 13;
  localparam int          FIN_SHIFT_B = 15;
  localparam logic [31:0] SEED_RESET  = 32'h0000_0000;

  typedef logic [2:0] state_t;
  localparam state_t S_IDLE = 3'd0;
  localparam state_t S_K1   = 3'd1;
  localparam state_t S_K2   = 3'd2;
  localparam state_t S_ACC  = 3'd3;
  localparam state_t S_TAIL = 3'd4;
  localparam state_t S_FIN  = 3'd5;

  typedef logic [2:0] op_t;
  localparam op_t OP_NONE = 3'd0;
  localparam op_t OP_K1   = 3'd1;
  localparam op_t OP_K2   = 3'd2;
  localparam op_t OP_ACC  = 3'd3;
  localparam op_t OP_TAIL = 3'd4;
  localparam op_t OP_FIN  = 3'd5;

  typedef struct packed {
    logic load;
    logic init;
    op_t  op;
  } dp_cmd_t;

  typedef struct packed {
    state_t state;
    logic   in_key;
  } ctl_sts_t;

endpackage

`default_nettype wire

@@ sv/mh2s_dp.sv @@
// datapath: seed register, word latch, shared constant multiplier, accumulator
// depends on mh2s_pkg
`timescale 1ns / 1ps
`default_nettype none

module mh2s_dp
  import mh2s_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_seed,
  input  wire dp_cmd_t     cmd,
  input  wire logic [31:0] in_key_word,
  input  wire logic [1:0]  in_valid_bytes,
  input  wire logic [30:0] in_key_length,
  output logic [31:0]      hash
);

  logic [31:0] seed_r;
  logic [31:0] word_r;
  logic [1:0]  nb_r;
  logic [31:0] k_r;
  logic [31:0] acc_r;
  logic [31:0] hash_r;
  logic [31:0] tail_mask;
  logic [31:0] mul_a;
  logic [31:0] prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
    end else if (cfg_we) begin
      seed_r <= cfg_seed;
    end
  end

  always_comb begin
    case (nb_r)
      2'd1:    tail_mask = 32'h0000_00ff;
      2'd2:    tail_mask = 32'h0000_ffff;
      2'd3:    tail_mask = 32'h00ff_ffff;
      default: tail_mask = 32'h0000_0000;
    endcase
  end

  always_comb begin
    unique case (cmd.op)
      OP_K1:   mul_a = word_r;
      OP_K2:   mul_a = k_r;
      OP_ACC:  mul_a = acc_r;
      OP_TAIL: mul_a = acc_r ^ (word_r & tail_mask);
      OP_FIN:  mul_a = acc_r ^ (acc_r >> FIN_SHIFT_A);
      default: mul_a = acc_r;
    endcase
  end

  assign prod = mul_a * MIX_MUL;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word_r <= in_key_word;
      nb_r   <= in_valid_bytes;
    end
    if (cmd.init) begin
      acc_r <= seed_r ^ {1'b0, in_key_length};
    end else begin
      unique case (cmd.op)
        OP_ACC:  acc_r <= prod ^ k_r;
        OP_TAIL: acc_r <= prod;
        default: acc_r <= acc_r;
      endcase
    end
    unique case (cmd.op)
      OP_K1:   k_r <= prod ^ (prod >> MIX_SHIFT);
      OP_K2:   k_r <= prod;
      default: k_r <= k_r;
    endcase
    if (cmd.op == OP_FIN) begin
      hash_r <= prod ^ (prod >> FIN_SHIFT_B);
    end
  end

  assign hash = hash_r;

endmodule

`default_nettype wire

@@ sv/mh2s_ctrl.sv @@
// controller: sequences the multiplier steps per word and owns both handshakes
// depends on mh2s_pkg
`timescale 1ns / 1ps
`default_nettype none

module mh2s_ctrl
  import mh2s_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] in_valid_bytes,
  input  wire logic       in_first_word,
  input  wire logic       in_last_word,
  output logic            out_valid,
  input  wire logic       out_ready,
  output dp_cmd_t         cmd,
  output ctl_sts_t        sts
);

  state_t state_r, state_nxt;
  logic   in_key_r, in_key_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   last_r, last_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    in_key_nxt    = in_key_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.load      = accept;
    cmd.init      = accept && in_first_word;
    cmd.op        = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_first_word || in_key_r)) begin
          in_key_nxt = 1'b1;
          last_nxt   = in_last_word;
          if (in_valid_bytes[2]) begin
            state_nxt = S_K1;
          end else if (in_valid_bytes[1:0] != 2'd0) begin
            state_nxt = S_TAIL;
          end else if (in_last_word) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_K1: begin
        cmd.op    = OP_K1;
        state_nxt = S_K2;
      end
      S_K2: begin
        cmd.op    = OP_K2;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.op    = OP_ACC;
        state_nxt = last_r ? S_FIN : S_IDLE;
      end
      S_TAIL: begin
        cmd.op    = OP_TAIL;
        state_nxt = last_r ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_FIN;
          out_valid_nxt = 1'b1;
          in_key_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_key_r    <= 1'b0;
      out_valid_r <= 1'b0;
      last_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_key_r    <= in_key_nxt;
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign sts.state  = state_r;
  assign sts.in_key = in_key_r;

endmodule

`default_nettype wire

@@ sv/murmurhash2_stream.sv @@
// streaming 32-bit murmurhash2: one key word per input item, hash on the last word
// top level, instantiates mh2s_ctrl and mh2s_dp, uses mh2s_pkg and the assertion macros
//
// input channel: in_valid/in_ready with key_word, valid_bytes, first_word,
// last_word and key_length; first_word opens a key, last_word closes it.
// a word that is neither first nor part of an open key is dropped.
// output channel: out_valid/out_ready with the finished hash.
// config channel: cfg_valid/cfg_ready with the seed, always ready; write it idle.
// sequence: a full word is accepted, then makes three passes through the
// one shared multiplier by the mixing constant; a short tail word makes one
// pass, and a zero-byte word is only accepted. a last word adds the final
// avalanche, and the hash shows on out_valid the cycle after that.
// the output register lets the next key start while a hash waits; only the
// avalanche step of the following key waits for out_ready.
// reset: synchronous active-low rst_n clears the seed, closes any key and
// drops a pending hash.
`timescale 1ns / 1ps
`default_nettype none
`include "murmurhash2_stream_defines.svh"

module murmurhash2_stream
  import mh2s_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_seed,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_key_word,
  input  wire logic [2:0]  in_valid_bytes,
  input  wire logic        in_first_word,
  input  wire logic        in_last_word,
  input  wire logic [30:0] in_key_length,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_hash
);

  dp_cmd_t  cmd;
  ctl_sts_t sts;

  assign cfg_ready = 1'b1;

  mh2s_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_valid_bytes (in_valid_bytes),
    .in_first_word  (in_first_word),
    .in_last_word   (in_last_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cmd            (cmd),
    .sts            (sts)
  );

  mh2s_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_seed       (cfg_seed),
    .cmd            (cmd),
    .in_key_word    (in_key_word),
    .in_valid_bytes (in_valid_bytes[1:0]),
    .in_key_length  (in_key_length),
    .hash           (out_hash)
  );

  `MH2S_ASSERT_NOW(a_hash_from_fin, $rose(out_valid), $past(sts.state) == S_FIN)
  `MH2S_ASSERT_NEXT(a_full_word_mixes,
    in_valid && in_ready && (in_first_word || sts.in_key) && in_valid_bytes[2],
    sts.state == S_K1)
  `MH2S_ASSERT_NEXT(a_k2_then_acc, sts.state == S_K2, sts.state == S_ACC)
  `MH2S_ASSERT_NEXT(a_fin_closes_key,
    sts.state == S_FIN && (!out_valid || out_ready), !sts.in_key && out_valid)

endmodule

`default_nettype wire
